FILE: rtl/core/sliding_median_with_payload_unit_assert.svh
// Assertion macros shared by the sliding median RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef SLIDING_MEDIAN_WITH_PAYLOAD_UNIT_ASSERT_SVH
`define SLIDING_MEDIAN_WITH_PAYLOAD_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SMWP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SMWP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/smwp_pkg.sv
// Package for the sliding median unit: operation and mode codes, field widths.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package smwp_pkg;

	// Fixed field widths
	localparam int STATUS_BITS = 8;
	localparam int OFFSET_BITS = 32;
	localparam int WIDTH_BITS  = 4;
	localparam int MODE_BITS   = 2;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = WIDTH_BITS;

	// Requested window is forced odd and masked to four bits
	localparam logic [WIDTH_BITS-1:0] WIDTH_MASK = 4'hf;
	localparam logic [WIDTH_BITS-1:0] WIDTH_ODD  = 4'h1;
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 4'h1;

	// Operation carried in tuser
	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	// Ranking mode
	typedef enum logic [MODE_BITS-1:0] {
		MODE_VALUE    = 2'd0,
		MODE_STATUS   = 2'd1,
		MODE_BYPASS   = 2'd2,
		MODE_RESERVED = 2'd3
	} mode_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_WINDOW_WIDTH = 1'b0,
		CFG_RANK_MODE    = 1'b1
	} cfg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/core/sliding_median_with_payload_unit.sv
// Sliding-window median with status and offset payload: top level.
// Depends on smwp_pkg and sliding_median_with_payload_unit_assert.svh.
//
// Usage:
// Input beats arrive on s_tvalid/s_tready. s_tuser is the operation (push or
// clear), s_tdata carries sample, status and offset. A push in a ranking mode
// stores the beat in the slot at the write pointer, ranks the window by
// pairwise comparison and returns the median slot on m_tvalid/m_tready.
// A push in bypass mode returns the beat unchanged; a clear returns nothing.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the window width
// and the ranking mode; writing the width returns the pointer to slot 0.
// A beat accepted at a clock edge sits in the input register, then loads the
// result register and raises m_tvalid once that register has room, with all
// 105 comparators, the rank counters and the median select between the two
// registers. Throughput is one beat per cycle when the receiver does not stall.
// Reset clears every slot to zero, sets the width to 1, the mode to ranking
// by value and the pointer to slot 0. When the receiver stalls, the result is
// held in the output register and one further beat waits in the input
// register; s_tready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

`include "sliding_median_with_payload_unit_assert.svh"

module sliding_median_with_payload_unit #(
	parameter int MAX_WINDOW  = 15,
	parameter int SAMPLE_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,

	// Configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [smwp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [smwp_pkg::CFG_DATA_BITS-1:0]  cfg_data,

	// Input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// tdata, from bit 0: sample, status_code, offset, zero padding
	input  wire logic [((SAMPLE_BITS + smwp_pkg::STATUS_BITS + smwp_pkg::OFFSET_BITS + 7) / 8)
		* 8 - 1:0] s_tdata,
	// tuser: operation
	input  wire logic                                s_tuser,

	// Result stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// tdata, from bit 0: median_sample, median_status, median_offset, zero padding
	output logic [((SAMPLE_BITS + smwp_pkg::STATUS_BITS + smwp_pkg::OFFSET_BITS + 7) / 8)
		* 8 - 1:0] m_tdata
);

	localparam int ST_W  = smwp_pkg::STATUS_BITS;
	localparam int OF_W  = smwp_pkg::OFFSET_BITS;
	localparam int WD_W  = smwp_pkg::WIDTH_BITS;
	localparam int DATA_W = ((SAMPLE_BITS + ST_W + OF_W + 7) / 8) * 8;
	// Largest odd width that fits the slot count
	localparam int CAP_INT = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
	localparam logic [WD_W-1:0] WIDTH_CAP = WD_W'(CAP_INT);

	// Configuration registers
	logic [WD_W-1:0]     width_q;
	smwp_pkg::mode_t     mode_q;
	logic [WD_W-1:0]     write_slot_q;

	// Window storage
	logic signed [SAMPLE_BITS-1:0] value_q  [MAX_WINDOW];
	logic signed [ST_W-1:0]        status_q [MAX_WINDOW];
	logic [OF_W-1:0]               offset_q [MAX_WINDOW];

	// Input register
	logic                          valid_s1;
	smwp_pkg::op_t                 op_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic signed [ST_W-1:0]        status_s1;
	logic [OF_W-1:0]               offset_s1;

	// Result register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] med_sample_q;
	logic signed [ST_W-1:0]        med_status_q;
	logic [OF_W-1:0]               med_offset_q;

	// Control
	logic            bypass;
	logic            by_status;
	logic            emit_s1;
	logic            store_s1;
	logic            clear_s1;
	logic            adv_s1;
	logic [WD_W-1:0] eff_w;
	logic [WD_W-1:0] raw_w;
	logic [WD_W-1:0] slot;
	logic [WD_W-1:0] next_slot;
	logic [WD_W-1:0] half_w;

	// Window after the pending write, and ranking terms
	logic signed [SAMPLE_BITS-1:0] value_n [MAX_WINDOW];
	logic signed [ST_W-1:0]        status_n [MAX_WINDOW];
	logic [OF_W-1:0]               offset_n [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] key_n [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]         in_win;
	logic [MAX_WINDOW-1:0]         ge [MAX_WINDOW];
	logic [WD_W-1:0]               rank_n [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]         pick;
	logic signed [SAMPLE_BITS-1:0] sel_sample;
	logic signed [ST_W-1:0]        sel_status;
	logic [OF_W-1:0]               sel_offset;

	// Mode decode and effective width
	assign bypass    = (mode_q == smwp_pkg::MODE_BYPASS) || (mode_q == smwp_pkg::MODE_RESERVED);
	assign by_status = (mode_q == smwp_pkg::MODE_STATUS);
	assign raw_w     = (width_q | smwp_pkg::WIDTH_ODD) & smwp_pkg::WIDTH_MASK;
	assign eff_w     = (raw_w > WIDTH_CAP) ? WIDTH_CAP : raw_w;
	assign half_w    = eff_w >> 1;

	// A stale pointer falls back to slot 0
	assign slot      = (write_slot_q < eff_w) ? write_slot_q : '0;
	assign next_slot = ((slot + WD_W'(1)) >= eff_w) ? '0 : slot + WD_W'(1);

	// Handshake: a clear needs no room in the result register
	assign emit_s1  = valid_s1 && (op_s1 == smwp_pkg::OP_PUSH);
	assign clear_s1 = valid_s1 && (op_s1 == smwp_pkg::OP_CLEAR);
	assign adv_s1   = valid_s1 && (!emit_s1 || !out_valid_q || m_tready);
	assign store_s1 = adv_s1 && emit_s1 && !bypass;
	assign s_tready = !valid_s1 || adv_s1;

	// Window contents with the pending beat written in, and ranking keys
	always_comb begin
		for (int k = 0; k < MAX_WINDOW; k++) begin
			if (emit_s1 && (WD_W'(k) == slot)) begin
				value_n[k]  = sample_s1;
				status_n[k] = status_s1;
				offset_n[k] = offset_s1;
			end else begin
				value_n[k]  = value_q[k];
				status_n[k] = status_q[k];
				offset_n[k] = offset_q[k];
			end
			key_n[k]  = by_status ? SAMPLE_BITS'(status_n[k]) : value_n[k];
			in_win[k] = (WD_W'(k) < eff_w);
		end
	end

	// Pairwise comparisons: ge[i][j] for i < j, the lower slot wins a tie
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			for (int j = 0; j < MAX_WINDOW; j++) begin
				ge[i][j] = (i < j) ? (key_n[i] >= key_n[j]) : 1'b0;
			end
		end
	end

	// Rank of each slot: points won against every other slot in the window
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			rank_n[i] = '0;
			for (int j = 0; j < MAX_WINDOW; j++) begin
				if (j > i)
					rank_n[i] = rank_n[i] + WD_W'(in_win[j] && ge[i][j]);
				else if (j < i)
					rank_n[i] = rank_n[i] + WD_W'(in_win[j] && !ge[j][i]);
			end
			pick[i] = in_win[i] && (rank_n[i] == half_w);
		end
	end

	// Ranks form a permutation, so exactly one slot is picked
	always_comb begin
		sel_sample = '0;
		sel_status = '0;
		sel_offset = '0;
		for (int k = 0; k < MAX_WINDOW; k++) begin
			if (pick[k]) begin
				sel_sample = sel_sample | value_n[k];
				sel_status = sel_status | status_n[k];
				sel_offset = sel_offset | offset_n[k];
			end
		end
	end

	// Configuration registers and write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= smwp_pkg::WIDTH_RESET;
			mode_q       <= smwp_pkg::MODE_VALUE;
			write_slot_q <= '0;
		end else begin
			if (cfg_we && (cfg_index == smwp_pkg::CFG_WINDOW_WIDTH)) begin
				width_q      <= cfg_data[WD_W-1:0];
				write_slot_q <= '0;
			end else if (store_s1) begin
				write_slot_q <= next_slot;
			end
			if (cfg_we && (cfg_index == smwp_pkg::CFG_RANK_MODE))
				mode_q <= smwp_pkg::mode_t'(cfg_data[smwp_pkg::MODE_BITS-1:0]);
		end
	end

	// Window storage: a push in a ranking mode writes one slot, clear zeroes values and offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_WINDOW; k++) begin
				value_q[k]  <= '0;
				status_q[k] <= '0;
				offset_q[k] <= '0;
			end
		end else if (adv_s1 && clear_s1) begin
			for (int k = 0; k < MAX_WINDOW; k++) begin
				value_q[k]  <= '0;
				offset_q[k] <= '0;
			end
		end else if (store_s1) begin
			for (int k = 0; k < MAX_WINDOW; k++) begin
				value_q[k]  <= value_n[k];
				status_q[k] <= status_n[k];
				offset_q[k] <= offset_n[k];
			end
		end
	end

	// Input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= smwp_pkg::op_t'(s_tuser);
			sample_s1 <= s_tdata[SAMPLE_BITS-1:0];
			status_s1 <= s_tdata[SAMPLE_BITS +: ST_W];
			offset_s1 <= s_tdata[SAMPLE_BITS + ST_W +: OF_W];
		end
	end

	// Result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload, bypass passes the beat through
	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			if (bypass) begin
				med_sample_q <= sample_s1;
				med_status_q <= status_s1;
				med_offset_q <= offset_s1;
			end else begin
				med_sample_q <= sel_sample;
				med_status_q <= sel_status;
				med_offset_q <= sel_offset;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_W'({med_offset_q, med_status_q, med_sample_q});

	// Checks on the pointer, the median select and result bookkeeping
	`SMWP_ASSERT_NOW(a_slot_in_window, clk, arst_n, 1'b1, write_slot_q < eff_w, "write pointer outside window")
	`SMWP_ASSERT_NOW(a_one_median, clk, arst_n, emit_s1 && !bypass, $onehot(pick), "median select not one-hot")
	`SMWP_ASSERT_NEXT(a_clear_silent, clk, arst_n, adv_s1 && clear_s1 && !out_valid_q, !m_tvalid, "clear produced a result beat")
	`SMWP_ASSERT_NEXT(a_push_result, clk, arst_n, adv_s1 && emit_s1, m_tvalid, "push lost its result beat")

endmodule

`default_nettype wire
